@@ rtl/htfr_pkg.sv @@
// ----------------------------------------------------------------------------
// htfr_pkg - shared definitions of the HTML text flow renderer
// Register map, character codes, reset values and the types that travel
// between the parser and the top level.
// ----------------------------------------------------------------------------
package htfr_pkg;

  // Entity name buffer depth (supported range 4 to 8).
  localparam int unsigned HTFR_ENTITY_NAME_MAX = 4;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned COLUMN_W = 7;
  localparam int unsigned ROW_W    = 5;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OUT_W    = 24;

  // Register indexes (byte address / 4).
  localparam logic [1:0] REG_WRAP_COLUMN = 2'd0;
  localparam logic [1:0] REG_TOP_ROW     = 2'd1;
  localparam logic [1:0] REG_END_ROW     = 2'd2;

  localparam logic [COLUMN_W-1:0] WRAP_COLUMN_RST = 7'd78;
  localparam logic [ROW_W-1:0]    TOP_ROW_RST     = 5'd4;
  localparam logic [ROW_W-1:0]    END_ROW_RST     = 5'd22;

  // Character codes the parser reacts to.
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_QUOT  = 8'h22;
  localparam logic [CHAR_W-1:0] CH_AMP   = 8'h26;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;

  typedef struct packed {
    logic [COLUMN_W-1:0] wrap_column;
    logic [ROW_W-1:0]    top_row;
    logic [ROW_W-1:0]    end_row;
  } cfg_t;

  typedef struct packed {
    logic                valid;
    logic [CHAR_W-1:0]   out_char;
    logic [COLUMN_W-1:0] out_column;
    logic [ROW_W-1:0]    out_row;
  } res_t;

endpackage

@@ rtl/htfr_parser.sv @@
// ----------------------------------------------------------------------------
// htfr_parser - page byte parser and cursor state
// Holds the parse mode, the cursor and the entity name buffer, and works out
// the character placed for the byte presented on step_byte.
// ----------------------------------------------------------------------------
module htfr_parser
  import htfr_pkg::*;
#(
  parameter int unsigned ENTITY_NAME_MAX = HTFR_ENTITY_NAME_MAX
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [CHAR_W-1:0] step_byte,
  input  logic              step_last,
  input  cfg_t              cfg,
  input  logic              top_load,
  input  logic [ROW_W-1:0]  top_value,
  output res_t              res
);

  localparam int unsigned IDX_W = $clog2(ENTITY_NAME_MAX);
  localparam int unsigned LEN_W = $clog2(ENTITY_NAME_MAX + 1);

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_TAG,
    MODE_ENTITY,
    MODE_DROP
  } mode_t;

  mode_t               mode_r, mode_nxt;
  logic                space_run_r, space_run_nxt;
  logic [COLUMN_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [CHAR_W-1:0]   name_r [ENTITY_NAME_MAX];
  logic                name_we;

  logic                row_open;
  logic                wrap_hit;
  logic [ROW_W:0]      row_inc;
  logic                place_ok;
  logic [COLUMN_W-1:0] place_col;
  logic [ROW_W-1:0]    place_row;
  logic                ent_hit;
  logic [CHAR_W-1:0]   ent_glyph;

  // Placement of a visible character at the cursor, with wrap.
  assign row_open  = row_r < cfg.end_row;
  assign wrap_hit  = col_r >= cfg.wrap_column;
  assign row_inc   = {1'b0, row_r} + 1'b1;
  assign place_ok  = row_open && (!wrap_hit || (row_inc < {1'b0, cfg.end_row}));
  assign place_col = wrap_hit ? '0 : col_r;
  assign place_row = wrap_hit ? row_inc[ROW_W-1:0] : row_r;

  // Entity lookup over the first four buffered name bytes.
  always_comb begin
    ent_hit   = 1'b0;
    ent_glyph = CH_SPACE;
    if (len_r == LEN_W'(4) && name_r[0] == "n" && name_r[1] == "b" &&
        name_r[2] == "s" && name_r[3] == "p") begin
      ent_hit   = 1'b1;
      ent_glyph = CH_SPACE;
    end else if (len_r == LEN_W'(2) && name_r[0] == "l" && name_r[1] == "t") begin
      ent_hit   = 1'b1;
      ent_glyph = CH_LT;
    end else if (len_r == LEN_W'(2) && name_r[0] == "g" && name_r[1] == "t") begin
      ent_hit   = 1'b1;
      ent_glyph = CH_GT;
    end else if (len_r == LEN_W'(3) && name_r[0] == "a" && name_r[1] == "m" &&
                 name_r[2] == "p") begin
      ent_hit   = 1'b1;
      ent_glyph = CH_AMP;
    end else if (len_r == LEN_W'(4) && name_r[0] == "q" && name_r[1] == "u" &&
                 name_r[2] == "o" && name_r[3] == "t") begin
      ent_hit   = 1'b1;
      ent_glyph = CH_QUOT;
    end
  end

  always_comb begin
    mode_nxt      = mode_r;
    space_run_nxt = space_run_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    len_nxt       = len_r;
    name_we       = 1'b0;
    res           = '0;
    case (mode_r)
      MODE_TAG: begin
        if (step_byte == CH_GT) begin
          mode_nxt = MODE_TEXT;
          if (col_r != '0 && row_open) begin
            col_nxt = '0;
            row_nxt = row_inc[ROW_W-1:0];
          end
        end
      end
      MODE_ENTITY: begin
        if (step_byte == CH_SEMI) begin
          mode_nxt = MODE_TEXT;
          len_nxt  = '0;
          if (ent_hit && row_open) begin
            row_nxt = place_row;
            col_nxt = place_col;
            if (place_ok) begin
              res     = '{1'b1, ent_glyph, place_col, place_row};
              col_nxt = place_col + 1'b1;
            end
          end
        end else if (len_r < LEN_W'(ENTITY_NAME_MAX)) begin
          name_we = 1'b1;
          len_nxt = len_r + 1'b1;
        end else begin
          mode_nxt = MODE_DROP;
        end
      end
      MODE_DROP: begin
        if (step_byte == CH_SEMI) begin
          mode_nxt = MODE_TEXT;
          len_nxt  = '0;
        end
      end
      default: begin
        if (step_byte == CH_SPACE || step_byte == CH_TAB) begin
          space_run_nxt = 1'b1;
          if (!space_run_r && row_open && !wrap_hit) begin
            res     = '{1'b1, CH_SPACE, col_r, row_r};
            col_nxt = col_r + 1'b1;
          end
        end else begin
          space_run_nxt = 1'b0;
          if (step_byte == CH_LT) begin
            mode_nxt = MODE_TAG;
          end else if (step_byte == CH_AMP) begin
            mode_nxt = MODE_ENTITY;
            len_nxt  = '0;
          end else if (step_byte != CH_CR && step_byte != CH_LF && row_open) begin
            row_nxt = place_row;
            col_nxt = place_col;
            if (place_ok) begin
              res     = '{1'b1, step_byte, place_col, place_row};
              col_nxt = place_col + 1'b1;
            end
          end
        end
      end
    endcase
    // The final byte of a page puts the parser back at the start.
    if (step_last) begin
      mode_nxt      = MODE_TEXT;
      space_run_nxt = 1'b0;
      col_nxt       = '0;
      row_nxt       = cfg.top_row;
      len_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_TEXT;
      space_run_r <= 1'b0;
      col_r       <= '0;
      row_r       <= TOP_ROW_RST;
      len_r       <= '0;
    end else begin
      if (step_en) begin
        mode_r      <= mode_nxt;
        space_run_r <= space_run_nxt;
        col_r       <= col_nxt;
        len_r       <= len_nxt;
        row_r       <= row_nxt;
      end
      if (top_load) begin
        row_r <= top_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && name_we) begin
      name_r[len_r[IDX_W-1:0]] <= step_byte;
    end
  end

endmodule

@@ rtl/html_text_flow_renderer_top.sv @@
// ----------------------------------------------------------------------------
// html_text_flow_renderer_top - HTML text flow renderer
// Strips tags, decodes a few entities and places the visible text of a page
// on a character grid, one page byte per transfer.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Signals                        Moves
//  -------  ---------  -----------------------------  ---------------------------
//  in       slave      in_tvalid/tready/tdata/tlast   one page byte, tlast ends page
//  out      master     out_tvalid/tready/tdata        one placed character
//  cfg      APB slave  cfg_psel/penable/pwrite/...    wrap_column, top_row, end_row
//
// The block takes one byte in every cycle that in_tready is high. A byte
// that places a character shows it on the out channel in the cycle after
// its transfer; the single output register lies between the two.
// in_tready stays high while the output register is empty or being taken,
// so a stall on the out side holds the input only when a result waits.
// Reset (rst_n, synchronous, active low) loads the register defaults and
// puts the parser in text mode at column zero of the top row.
// ----------------------------------------------------------------------------
module html_text_flow_renderer_top
  import htfr_pkg::*;
#(
  parameter int unsigned ENTITY_NAME_MAX = HTFR_ENTITY_NAME_MAX
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input stream.
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] in_byte
  input  logic              in_tlast,   // last_byte
  // Result stream.
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,  // [7:0] out_char, [14:8] out_column,
                                        // [19:15] out_row, [23:20] zero
  // Configuration port.
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t                cfg_r;
  logic                cfg_wr;
  logic [1:0]          cfg_idx;
  logic                in_fire;
  res_t                res;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r;
  logic [COLUMN_W-1:0] out_column_r;
  logic [ROW_W-1:0]    out_row_r;

  // Register writes complete in the access phase; pready is never pulled low.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wrap_column <= WRAP_COLUMN_RST;
      cfg_r.top_row     <= TOP_ROW_RST;
      cfg_r.end_row     <= END_ROW_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WRAP_COLUMN: cfg_r.wrap_column <= cfg_pwdata[COLUMN_W-1:0];
        REG_TOP_ROW:     cfg_r.top_row     <= cfg_pwdata[ROW_W-1:0];
        REG_END_ROW:     cfg_r.end_row     <= cfg_pwdata[ROW_W-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WRAP_COLUMN: cfg_prdata = DATA_W'(cfg_r.wrap_column);
      REG_TOP_ROW:     cfg_prdata = DATA_W'(cfg_r.top_row);
      REG_END_ROW:     cfg_prdata = DATA_W'(cfg_r.end_row);
      default:         cfg_prdata = '0;
    endcase
  end

  // A new byte is taken whenever the output register is free this cycle.
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // Writing top_row moves the cursor to the new row at once.
  htfr_parser #(
    .ENTITY_NAME_MAX (ENTITY_NAME_MAX)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (in_fire),
    .step_byte (in_tdata),
    .step_last (in_tlast),
    .cfg       (cfg_r),
    .top_load  (cfg_wr && cfg_idx == REG_TOP_ROW),
    .top_value (cfg_pwdata[ROW_W-1:0]),
    .res       (res)
  );

  // Output register: loads on every input transfer that places a character,
  // otherwise empties when its content is taken.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (in_fire) begin
      out_valid_nxt = res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res.valid) begin
      out_char_r   <= res.out_char;
      out_column_r <= res.out_column;
      out_row_r    <= res.out_row;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_row_r, out_column_r, out_char_r};

  // A character is never placed at or beyond the row limit.
  a_row_below_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res.valid) |-> (res.out_row < cfg_r.end_row))
    else $error("character placed at or past end_row");

  // Input is held back only while a result waits in the output register.
  a_ready_only_blocked_by_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with an empty output register");

  // A transfer that places a character presents it in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res.valid) |=>
      (out_tvalid && out_tdata[7:0] == $past(res.out_char) &&
       out_tdata[14:8] == $past(res.out_column)))
    else $error("placed character missing from output register");

  // A transfer without a character leaves nothing behind once the old one is taken.
  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !res.valid) |=> !out_tvalid)
    else $error("output valid without a placed character");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb - self-checking bench for the HTML text flow renderer
// Streams page bytes into the block and compares every placed character with
// a behavioral model of the parser. The model covers tag stripping, entity
// decode, space collapsing, wrapping and the row limit. A short table of
// directed bytes comes first. Random pages follow, under a series of register
// settings, with random gaps on the input side and stalls on the output side.
// ----------------------------------------------------------------------------
module tb;
  import htfr_pkg::*;

  localparam int DIR_ROWS        = 25;
  localparam int PHASES          = 11;
  localparam int PHASE_ITEMS     = 120;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef enum logic [1:0] {PM_TEXT, PM_TAG, PM_ENTITY, PM_DROP} parse_mode_t;

  // One placed character as it leaves the block.
  typedef struct packed {
    logic [CHAR_W-1:0]   ch;
    logic [COLUMN_W-1:0] col;
    logic [ROW_W-1:0]    row;
  } placed_t;

  // A byte offered to the block. When pin is set, the expected character is
  // the one typed into the row, not the one the model computes.
  typedef struct packed {
    logic                pin;
    placed_t             glyph;
  } pinned_t;

  typedef struct packed {
    logic [CHAR_W-1:0]   b;
    logic                last;
    logic                pin;
    logic [CHAR_W-1:0]   ch;
    logic [COLUMN_W-1:0] col;
    logic [ROW_W-1:0]    row;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = '0;   // [7:0] in_byte
  logic              in_tlast = 1'b0; // last_byte
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;       // [7:0] out_char, [14:8] out_column,
                                      // [19:15] out_row, [23:20] zero
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  html_text_flow_renderer_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // The run must end long before this, even with every item waiting out the
  // slowest receiver pattern and the longest sender gap.
  initial begin : watchdog
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Parser model: register shadows and parse state.
  // --------------------------------------------------------------------------
  logic [COLUMN_W-1:0] wrap_col_r;
  logic [ROW_W-1:0]    top_row_r;
  logic [ROW_W-1:0]    end_row_r;

  parse_mode_t         pmode;
  logic                in_space_run;
  logic [COLUMN_W-1:0] col_now;
  logic [ROW_W-1:0]    row_now;
  logic [CHAR_W-1:0]   ent_buf [HTFR_ENTITY_NAME_MAX];
  logic [$clog2(HTFR_ENTITY_NAME_MAX+1)-1:0] ent_len;

  placed_t glyph_q [$];   // characters the block still owes us, oldest first
  pinned_t pinned_q [$];  // one entry per byte offered and not yet taken
  int      mismatches = 0;
  int      burst_left = 0;
  bit      hold_off_req = 1'b0;
  logic [CHAR_W-1:0] page_bytes [$];

  function automatic void start_page();
    pmode        = PM_TEXT;
    in_space_run = 1'b0;
    col_now      = '0;
    row_now      = top_row_r;
    ent_len      = '0;
  endfunction

  function automatic bit emit(input logic [CHAR_W-1:0] ch, output placed_t g);
    g = {ch, col_now, row_now};
    col_now++;
    return 1'b1;
  endfunction

  // Puts a visible character down, wrapping first if the row is full. Nothing
  // goes at or past the row limit.
  function automatic bit place_glyph(input logic [CHAR_W-1:0] ch, output placed_t g);
    g = '0;
    if (row_now >= end_row_r) return 1'b0;
    if (col_now >= wrap_col_r) begin
      col_now = '0;
      row_now++;
      if (row_now >= end_row_r) return 1'b0;
    end
    return emit(ch, g);
  endfunction

  // Names are case-sensitive, and only the first ent_len bytes take part.
  function automatic bit decode_entity(output logic [CHAR_W-1:0] glyph);
    logic [31:0] nm;
    nm = {ent_buf[0], ent_buf[1], ent_buf[2], ent_buf[3]};
    decode_entity = 1'b1;
    glyph = CH_SPACE;
    if (ent_len == 2 && nm[31:16] == "lt")      glyph = CH_LT;
    else if (ent_len == 2 && nm[31:16] == "gt") glyph = CH_GT;
    else if (ent_len == 3 && nm[31:8] == "amp") glyph = CH_AMP;
    else if (ent_len == 4 && nm == "nbsp")      glyph = CH_SPACE;
    else if (ent_len == 4 && nm == "quot")      glyph = CH_QUOT;
    else decode_entity = 1'b0;
  endfunction

  // Advances the model by one page byte; returns 1 when a character is placed.
  function automatic bit render_byte(input logic [CHAR_W-1:0] b, input logic last,
                                     output placed_t g);
    logic [CHAR_W-1:0] glyph;
    bit made;
    made = 1'b0;
    g = '0;
    case (pmode)
      PM_TAG: begin
        // Leaving a tag breaks the line, unless we are already at its start.
        if (b == CH_GT) begin
          pmode = PM_TEXT;
          if (col_now != 0 && row_now < end_row_r) begin
            col_now = '0;
            row_now++;
          end
        end
      end
      PM_ENTITY: begin
        if (b == CH_SEMI) begin
          pmode = PM_TEXT;
          if (decode_entity(glyph)) made = place_glyph(glyph, g);
          ent_len = '0;
        end else if (ent_len < HTFR_ENTITY_NAME_MAX) begin
          ent_buf[ent_len] = b;
          ent_len++;
        end else begin
          pmode = PM_DROP;
        end
      end
      PM_DROP: begin
        if (b == CH_SEMI) begin
          pmode = PM_TEXT;
          ent_len = '0;
        end
      end
      default: begin
        if (b == CH_SPACE || b == CH_TAB) begin
          // A space past the wrap column is simply lost; it never wraps.
          if (!in_space_run && row_now < end_row_r && col_now < wrap_col_r)
            made = emit(CH_SPACE, g);
          in_space_run = 1'b1;
        end else begin
          in_space_run = 1'b0;
          if (b == CH_LT) pmode = PM_TAG;
          else if (b == CH_AMP) begin
            pmode = PM_ENTITY;
            ent_len = '0;
          end else if (b != CH_CR && b != CH_LF) made = place_glyph(b, g);
        end
      end
    endcase
    if (last) start_page();
    return made;
  endfunction

  task automatic note_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("ERROR: %s got 0x%0h expected 0x%0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Scoreboard. Both channels are sampled at the rising edge, before any of
  // this edge's nonblocking updates land, so the values seen are the ones that
  // took part in the transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    placed_t got_g;
    placed_t want;
    pinned_t hint;
    bit      made;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        hint = (pinned_q.size() != 0) ? pinned_q.pop_front() : '0;
        made = render_byte(in_tdata, in_tlast, got_g);
        if (hint.pin) glyph_q.push_back(hint.glyph);
        else if (made) glyph_q.push_back(got_g);
      end
      if (out_tvalid && out_tready) begin
        if (glyph_q.size() == 0) begin
          note_mismatch("result with nothing expected", 32'(out_tdata), 0);
        end else begin
          want = glyph_q.pop_front();
          if (out_tdata[CHAR_W-1:0] !== want.ch)
            note_mismatch("out_char", 32'(out_tdata[CHAR_W-1:0]), 32'(want.ch));
          if (out_tdata[CHAR_W +: COLUMN_W] !== want.col)
            note_mismatch("out_column", 32'(out_tdata[CHAR_W +: COLUMN_W]),
                          32'(want.col));
          if (out_tdata[CHAR_W+COLUMN_W +: ROW_W] !== want.row)
            note_mismatch("out_row", 32'(out_tdata[CHAR_W+COLUMN_W +: ROW_W]),
                          32'(want.row));
          if (out_tdata[OUT_W-1:CHAR_W+COLUMN_W+ROW_W] !== '0)
            note_mismatch("tdata padding",
                          32'(out_tdata[OUT_W-1:CHAR_W+COLUMN_W+ROW_W]), 0);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. It switches between stall patterns of random length, one of
  // which never stalls. On request it holds off for a long stretch so that
  // the output register fills and the block stops taking bytes.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int style;
    int left;
    style = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        if (left == 0) begin
          style = $urandom_range(0, 3);
          left = $urandom_range(8, 96);
        end
        left--;
        case (style)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Offers one byte and returns at the edge of its transfer. Bytes go
  // out in bursts; at the end of a burst tvalid drops for a random gap.
  // --------------------------------------------------------------------------
  task automatic offer(input logic [CHAR_W-1:0] b, input logic last, input logic pin,
                       input placed_t glyph);
    int gap;
    pinned_q.push_back({pin, glyph});
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                              : $urandom_range(1, 16);
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops sending and waits for every owed character. It first waits for an edge so
  // that the scoreboard has seen the last transfer; a byte that places nothing
  // may still be in flight, so the task waits on after the queue is empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (glyph_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // APB write, then a read back of the same register. The model's shadow is
  // updated at the edge of the write, and a new top row also moves the cursor.
  task automatic cfg_write(input logic [1:0] idx, input int unsigned val);
    int unsigned want;
    case (idx)
      REG_WRAP_COLUMN: want = val & ((1 << COLUMN_W) - 1);
      default:         want = val & ((1 << ROW_W) - 1);
    endcase
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_WRAP_COLUMN: wrap_col_r = COLUMN_W'(want);
      REG_TOP_ROW: begin
        top_row_r = ROW_W'(want);
        row_now   = ROW_W'(want);
      end
      default:         end_row_r = ROW_W'(want);
    endcase
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) note_mismatch("register read back", cfg_prdata, want);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Fills page_bytes with one piece of page: mostly well-formed words, space
  // runs, tags and entities, with some broken entities and raw noise.
  function automatic void build_fragment();
    int kind;
    int n;
    logic [31:0] nm;
    logic [CHAR_W-1:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      n = $urandom_range(1, 10);
      repeat (n) page_bytes.push_back(($urandom_range(0, 5) == 0)
                                      ? CHAR_W'($urandom_range(8'h21, 8'h7E))
                                      : CHAR_W'($urandom_range("a", "z")));
    end else if (kind < 50) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0:       page_bytes.push_back(CH_SPACE);
          1:       page_bytes.push_back(CH_TAB);
          2:       page_bytes.push_back(CH_CR);
          default: page_bytes.push_back(CH_LF);
        endcase
      end
    end else if (kind < 63) begin
      page_bytes.push_back(CH_LT);
      n = $urandom_range(0, 6);
      repeat (n) begin
        c = CHAR_W'($urandom_range(0, 255));
        page_bytes.push_back((c == CH_GT) ? "a" : c);
      end
      page_bytes.push_back(CH_GT);
    end else if (kind < 78) begin
      case ($urandom_range(0, 4))
        0:       begin nm = "nbsp"; n = 4; end
        1:       begin nm = "lt";   n = 2; end
        2:       begin nm = "gt";   n = 2; end
        3:       begin nm = "amp";  n = 3; end
        default: begin nm = "quot"; n = 4; end
      endcase
      // Now and then the first letter goes upper case, which must not decode.
      if ($urandom_range(0, 5) == 0) nm[8*(n-1) +: 8] ^= 8'h20;
      page_bytes.push_back(CH_AMP);
      for (int j = n - 1; j >= 0; j--) page_bytes.push_back(nm[8*j +: 8]);
      page_bytes.push_back(CH_SEMI);
    end else if (kind < 89) begin
      // Unknown names, from empty up to twice the buffer depth.
      page_bytes.push_back(CH_AMP);
      n = (kind < 84) ? $urandom_range(0, HTFR_ENTITY_NAME_MAX)
                      : $urandom_range(HTFR_ENTITY_NAME_MAX + 1, 2 * HTFR_ENTITY_NAME_MAX);
      repeat (n) begin
        c = CHAR_W'($urandom_range(0, 255));
        page_bytes.push_back((c == CH_SEMI) ? "z" : c);
      end
      page_bytes.push_back(CH_SEMI);
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) page_bytes.push_back(CHAR_W'($urandom_range(0, 255)));
    end
  endfunction

  // Directed bytes under the reset register values (wrap 78, top row 4, end row 22).
  // Rows with pin set carry the character the block has to place; the rest
  // are checked against the model.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{"A",    1'b0, 1'b1, "A",   7'd0, 5'd4},  // first byte after reset
    '{8'hFF,  1'b0, 1'b1, 8'hFF, 7'd1, 5'd4},  // top code is placed as-is
    '{8'h00,  1'b0, 1'b1, 8'h00, 7'd2, 5'd4},  // so is NUL
    '{CH_SPACE, 1'b0, 1'b1, CH_SPACE, 7'd3, 5'd4},
    '{CH_TAB, 1'b0, 1'b0, 8'h00, 7'd0, 5'd0},  // part of the same space run
    '{CH_CR,  1'b0, 1'b0, 8'h00, 7'd0, 5'd0},  // dropped, but ends the run
    '{CH_TAB, 1'b0, 1'b0, 8'h00, 7'd0, 5'd0},
    '{CH_LT,  1'b0, 1'b0, 8'h00, 7'd0, 5'd0},
    '{"b",    1'b0, 1'b0, 8'h00, 7'd0, 5'd0},
    '{CH_GT,  1'b0, 1'b0, 8'h00, 7'd0, 5'd0},  // tag end breaks the line
    '{CH_AMP, 1'b0, 1'b0, 8'h00, 7'd0, 5'd0},
    '{"l",    1'b0, 1'b0, 8'h00, 7'd0, 5'd0},
    '{"t",    1'b0, 1'b0, 8'h00, 7'd0, 5'd0},
    '{CH_SEMI, 1'b0, 1'b0, 8'h00, 7'd0, 5'd0},
    '{CH_AMP, 1'b0, 1'b0, 8'h00, 7'd0, 5'd0},
    '{"a",    1'b0, 1'b0, 8'h00, 7'd0, 5'd0},
    '{"m",    1'b0, 1'b0, 8'h00, 7'd0, 5'd0},
    '{"p",    1'b0, 1'b0, 8'h00, 7'd0, 5'd0},
    '{CH_SEMI, 1'b0, 1'b0, 8'h00, 7'd0, 5'd0},
    '{CH_AMP, 1'b0, 1'b0, 8'h00, 7'd0, 5'd0},  // unknown name, dropped
    '{"x",    1'b0, 1'b0, 8'h00, 7'd0, 5'd0},
    '{CH_SEMI, 1'b0, 1'b0, 8'h00, 7'd0, 5'd0},
    '{CH_LT,  1'b0, 1'b0, 8'h00, 7'd0, 5'd0},  // tag left open at page end
    '{"p",    1'b1, 1'b0, 8'h00, 7'd0, 5'd0},
    '{"Z",    1'b0, 1'b1, "Z",   7'd0, 5'd4}   // new page starts at the top row
  };

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed table, then random pages under a series of
  // register settings. Registers change only with the block idle.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned wrap_v;
    int unsigned top_v;
    int unsigned end_v;
    int          sent;
    int          page_left;
    logic        last;
    bit          paused;

    wrap_col_r = WRAP_COLUMN_RST;
    top_row_r  = TOP_ROW_RST;
    end_row_r  = END_ROW_RST;
    foreach (ent_buf[k]) ent_buf[k] = '0;
    start_page();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      offer(dir_rows[i].b, dir_rows[i].last, dir_rows[i].pin,
            {dir_rows[i].ch, dir_rows[i].col, dir_rows[i].row});
    settle();

    page_left = $urandom_range(4, 160);
    for (int ph = 0; ph < PHASES; ph++) begin
      // The first settings cover the extremes: widest and narrowest wrap, a
      // zero wrap column, a row limit below and equal to the top row.
      case (ph)
        0: begin wrap_v = 80; top_v = 0;  end_v = 25; end
        1: begin wrap_v = 1;  top_v = 24; end_v = 25; end
        2: begin wrap_v = 0;  top_v = 2;  end_v = 10; end
        3: begin wrap_v = 5;  top_v = 20; end_v = 1;  end
        4: begin wrap_v = 12; top_v = 3;  end_v = 8;  end
        5: begin wrap_v = 7;  top_v = 9;  end_v = 9;  end
        default: begin
          wrap_v = $urandom_range(1, 80);
          top_v  = $urandom_range(0, 24);
          end_v  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 25)
                                               : $urandom_range(top_v + 1, 25);
        end
      endcase
      cfg_write(REG_WRAP_COLUMN, wrap_v);
      cfg_write(REG_END_ROW, end_v);
      cfg_write(REG_TOP_ROW, top_v);

      // In the widest setting the receiver first holds off for a long time
      // while bytes keep coming; later the sender stops until all is drained.
      if (ph == 0) hold_off_req = 1'b1;
      sent = 0;
      paused = 1'b0;
      while (sent < PHASE_ITEMS) begin
        build_fragment();
        while (page_bytes.size() != 0) begin
          page_left--;
          last = (page_left == 0);
          if (last) page_left = $urandom_range(4, 160);
          offer(page_bytes.pop_front(), last, 1'b0, '0);
          sent++;
        end
        if (ph == 0 && !paused && sent >= 2 * PHASE_ITEMS / 3) begin
          settle();
          paused = 1'b1;
        end
      end
      settle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && glyph_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/htfr_pkg.sv
rtl/htfr_parser.sv
rtl/html_text_flow_renderer_top.sv
tb/tb.sv
